@@ hw/rtl/sfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared types, constants and the CRC-16/XMODEM byte update for the serial
// frame receiver.
// ----------------------------------------------------------------------------
package sfrc_pkg;

  // frame buffer depth in bytes
  localparam int MAX_FRAME = 64;
  localparam int TOTAL_CAP = 149;
  localparam int LEN_LIMIT = 135;
  localparam int FRAME_CAP = (MAX_FRAME < TOTAL_CAP) ? MAX_FRAME : TOTAL_CAP;
  localparam int CNT_W     = $clog2(FRAME_CAP + 1);
  localparam int WIDE_W    = 10;
  localparam int LONG_MIN_TOTAL = 7;
  localparam int LEN_POS_COUNT  = 5;
  localparam int POS_MAX   = 63;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int SLEN_W    = 7;
  localparam int TOTAL_W   = 8;
  localparam int CRC_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SHORT_HEADER_RST = 8'h01;
  localparam logic [BYTE_W-1:0] LONG_HEADER_RST  = 8'h5A;
  localparam logic [SLEN_W-1:0] SHORT_LEN_RST    = 7'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_HEADER = 2'd0,
    REG_LONG_HEADER  = 2'd1,
    REG_SHORT_LEN    = 2'd2
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROGRESS   = 3'd0,
    ST_CRC_GOOD   = 3'd1,
    ST_CRC_BAD    = 3'd2,
    ST_SHORT_DONE = 3'd3,
    ST_ABANDON    = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] short_header;
    logic [BYTE_W-1:0] long_header;
    logic [SLEN_W-1:0] short_frame_length;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic              last;
    status_t           status;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = {c_in[7:0], c_in[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

@@ hw/rtl/sfrc_cfg.sv @@
// ----------------------------------------------------------------------------
// sfrc_cfg
// Configuration registers: header bytes and short frame length.
// ----------------------------------------------------------------------------
module sfrc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfrc_pkg::BYTE_W-1:0]    cfg_data,
  output sfrc_pkg::cfg_t                 cfg
);
  import sfrc_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_header       <= SHORT_HEADER_RST;
      regs.long_header        <= LONG_HEADER_RST;
      regs.short_frame_length <= SHORT_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHORT_HEADER: regs.short_header       <= cfg_data;
        REG_LONG_HEADER:  regs.long_header        <= cfg_data;
        REG_SHORT_LEN:    regs.short_frame_length <= cfg_data[SLEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sfrc_core.sv @@
// ----------------------------------------------------------------------------
// sfrc_core
// Frame state and the single-pass byte step: header hunt, length capture,
// running CRC, trailer check and overflow abandon.
// ----------------------------------------------------------------------------
module sfrc_core (
  input  logic                        clk,
  input  logic                        rst,
  input  sfrc_pkg::cfg_t              cfg,
  input  logic                        step,
  input  logic [sfrc_pkg::BYTE_W-1:0] item_byte,
  output logic                        res_valid,
  output sfrc_pkg::result_t           res
);
  import sfrc_pkg::*;

  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [TOTAL_W-1:0] expected_total, expected_total_next;
  logic               long_frame, long_frame_next;
  logic [CRC_W-1:0]   running_crc, running_crc_next;
  logic [BYTE_W-1:0]  trailer_high, trailer_high_next;

  logic [WIDE_W-1:0]  count_w;
  logic [WIDE_W-1:0]  count_inc_w;
  logic [WIDE_W-1:0]  total_w;
  logic [WIDE_W-1:0]  len_total;
  logic [POS_W-1:0]   pos;
  logic               crc_ok;

  assign count_w     = WIDE_W'(byte_count);
  assign count_inc_w = count_w + WIDE_W'(1);
  assign total_w     = WIDE_W'(expected_total);
  assign len_total   = WIDE_W'(item_byte) + WIDE_W'(LONG_MIN_TOTAL);
  assign pos         = (count_w > WIDE_W'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(byte_count);

  always_comb begin
    byte_count_next     = byte_count;
    expected_total_next = expected_total;
    long_frame_next     = long_frame;
    running_crc_next    = running_crc;
    trailer_high_next   = trailer_high;
    res_valid           = 1'b0;
    res.data_byte       = item_byte;
    res.position        = pos;
    res.last            = 1'b0;
    res.status          = ST_PROGRESS;
    crc_ok              = 1'b0;

    if (byte_count == '0) begin
      res.position = '0;
      if (item_byte == cfg.short_header) begin
        long_frame_next     = 1'b0;
        expected_total_next = TOTAL_W'(cfg.short_frame_length);
        running_crc_next    = '0;
        byte_count_next     = CNT_W'(1);
        res_valid           = 1'b1;
      end else if (item_byte == cfg.long_header) begin
        long_frame_next     = 1'b1;
        expected_total_next = TOTAL_W'(LONG_MIN_TOTAL);
        running_crc_next    = crc_byte('0, item_byte);
        byte_count_next     = CNT_W'(1);
        res_valid           = 1'b1;
      end
    end else if (count_w >= WIDE_W'(MAX_FRAME)) begin
      byte_count_next = '0;
      res_valid       = 1'b1;
      res.last        = 1'b1;
      res.status      = ST_ABANDON;
    end else begin
      byte_count_next = CNT_W'(count_inc_w);
      res_valid       = 1'b1;
      if (long_frame) begin
        if (count_w + WIDE_W'(2) < total_w) begin
          running_crc_next = crc_byte(running_crc, item_byte);
        end else if (count_w + WIDE_W'(2) == total_w) begin
          trailer_high_next = item_byte;
        end
      end
      if (long_frame && count_inc_w == WIDE_W'(LEN_POS_COUNT)) begin
        expected_total_next = (len_total > WIDE_W'(TOTAL_CAP)) ?
                              TOTAL_W'(TOTAL_CAP) : TOTAL_W'(len_total);
      end else if (count_inc_w >= total_w) begin
        byte_count_next = '0;
        res.last        = 1'b1;
        if (long_frame) begin
          crc_ok = ({trailer_high, item_byte} == running_crc_next) &&
                   (total_w - WIDE_W'(2) <= WIDE_W'(LEN_LIMIT));
          res.status = crc_ok ? ST_CRC_GOOD : ST_CRC_BAD;
        end else begin
          res.status = ST_SHORT_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      expected_total <= TOTAL_W'(LONG_MIN_TOTAL);
      long_frame     <= 1'b0;
      running_crc    <= '0;
      trailer_high   <= '0;
    end else if (step) begin
      byte_count     <= byte_count_next;
      expected_total <= expected_total_next;
      long_frame     <= long_frame_next;
      running_crc    <= running_crc_next;
      trailer_high   <= trailer_high_next;
    end
  end

  // result flags agree: last exactly when status is final
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last == (res.status != ST_PROGRESS)))
    else $error("last and status disagree");

  // frame count never passes the buffer depth
  assert property (@(posedge clk) disable iff (rst)
    WIDE_W'(byte_count) <= WIDE_W'(FRAME_CAP))
    else $error("byte count beyond buffer");

  // a closing transaction returns the receiver to hunting
  assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.last |=> byte_count == '0)
    else $error("frame not closed after last byte");

  // long frame total stays in its legal range
  assert property (@(posedge clk) disable iff (rst)
    long_frame && byte_count != '0 |->
      (WIDE_W'(expected_total) >= WIDE_W'(LONG_MIN_TOTAL)) &&
      (WIDE_W'(expected_total) <= WIDE_W'(TOTAL_CAP)))
    else $error("long frame total out of range");

endmodule

@@ hw/rtl/serial_frame_receiver_crc_check_top.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc_check_top
// Byte-stream deframer with length-prefixed frames and CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// One received byte per cycle is sustained while the output is not stalled. A
// byte is held in an input register, goes through one pass of frame logic
// (header match, length capture, CRC byte update and trailer compare) and
// lands in the result register, from which its transaction is presented;
// a stalled output holds it there. Bytes seen while hunting that match no
// header produce no transaction. The configuration registers are written
// through their own port with no wait.
module serial_frame_receiver_crc_check_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfrc_pkg::BYTE_W-1:0]     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfrc_pkg::BYTE_W-1:0]     data_byte,
  output logic [sfrc_pkg::POS_W-1:0]      position,
  output logic                           last,
  output logic [sfrc_pkg::STATUS_W-1:0]   status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfrc_pkg::BYTE_W-1:0]     cfg_data
);
  import sfrc_pkg::*;

  cfg_t              cfg;
  logic              in_q_valid;
  logic [BYTE_W-1:0] in_q_byte;
  logic              step;
  logic              res_valid;
  result_t           res;
  result_t           out_q;

  sfrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .item_byte (in_q_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  assign step     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign data_byte = out_q.data_byte;
  assign position  = out_q.position;
  assign last      = out_q.last;
  assign status    = out_q.status;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc_check_top testbench
// Sends byte streams of short frames, CRC-16/XMODEM length-prefixed frames,
// corrupted and cut-off frames and line noise into the deframer. A built-in
// deframer model predicts every output transaction, and each one is checked
// field by field. The header and short-length registers are rewritten between
// phases while the block is idle. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import sfrc_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int KEEP_MAX     = 70;
  localparam int PHASE_BYTES  = 45;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   data_byte;
  logic [POS_W-1:0]    position;
  logic                last;
  logic [STATUS_W-1:0] status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SHORT_HEADER;
  logic [BYTE_W-1:0]   cfg_data = '0;

  logic [BYTE_W-1:0] byte_stream[$];
  result_t           results_due[$];
  int                bytes_queued = 0;
  int                bytes_sent = 0;
  int                errors = 0;
  int                cycle_count = 0;
  int                send_gap = 0;
  int                stall_left = 0;
  bit                steady = 1'b0;

  // register mirror
  logic [BYTE_W-1:0] hdr_short = SHORT_HEADER_RST;
  logic [BYTE_W-1:0] hdr_long  = LONG_HEADER_RST;
  logic [SLEN_W-1:0] short_len = SHORT_LEN_RST;

  // deframer state
  int                frame_count = 0;
  int                frame_total = LONG_MIN_TOTAL;
  bit                frame_is_long = 1'b0;
  logic [CRC_W-1:0]  frame_crc = '0;
  logic [BYTE_W-1:0] crc_high_byte = '0;

  serial_frame_receiver_crc_check_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .position  (position),
    .last      (last),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CRC_W-1:0] crc16_xmodem_update(input logic [CRC_W-1:0] c,
                                                           input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  function automatic result_t make_result(input logic [BYTE_W-1:0] b, input int idx,
                                          input logic lst, input status_t st);
    result_t r;
    r.data_byte = b;
    r.position  = POS_W'((idx > POS_MAX) ? POS_MAX : idx);
    r.last      = lst;
    r.status    = st;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
    int      idx;
    int      t;
    status_t st;
    if (frame_count == 0) begin
      if (b == hdr_short) begin
        frame_is_long = 1'b0;
        frame_total   = short_len;
        frame_crc     = '0;
      end else if (b == hdr_long) begin
        frame_is_long = 1'b1;
        frame_total   = LONG_MIN_TOTAL;
        frame_crc     = crc16_xmodem_update('0, b);
      end else begin
        return 1'b0;
      end
      frame_count = 1;
      r = make_result(b, 0, 1'b0, ST_PROGRESS);
      return 1'b1;
    end
    if (frame_count >= MAX_FRAME) begin
      idx = frame_count;
      frame_count = 0;
      r = make_result(b, idx, 1'b1, ST_ABANDON);
      return 1'b1;
    end
    idx = frame_count;
    frame_count++;
    if (frame_is_long) begin
      if (idx + 2 < frame_total) begin
        frame_crc = crc16_xmodem_update(frame_crc, b);
      end else if (idx + 2 == frame_total) begin
        crc_high_byte = b;
      end
      if (frame_count == LEN_POS_COUNT) begin
        t = int'(b) + LONG_MIN_TOTAL;
        frame_total = (t > TOTAL_CAP) ? TOTAL_CAP : t;
        r = make_result(b, idx, 1'b0, ST_PROGRESS);
        return 1'b1;
      end
    end
    if (frame_count >= frame_total) begin
      if (!frame_is_long) begin
        st = ST_SHORT_DONE;
      end else if ({crc_high_byte, b} == frame_crc && frame_total - 2 <= LEN_LIMIT) begin
        st = ST_CRC_GOOD;
      end else begin
        st = ST_CRC_BAD;
      end
      frame_count = 0;
      r = make_result(b, idx, 1'b1, st);
      return 1'b1;
    end
    r = make_result(b, idx, 1'b0, ST_PROGRESS);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_byte(input logic [BYTE_W-1:0] b);
    byte_stream.push_back(b);
    bytes_queued++;
  endfunction

  function automatic int queue_long_frame(input int len, input bit bad_crc, input int keep);
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] b;
    int                total;
    int                n;
    total = len + LONG_MIN_TOTAL;
    n = (total < keep) ? total : keep;
    if (n > KEEP_MAX) n = KEEP_MAX;
    c = '0;
    for (int p = 0; p < n; p++) begin
      if (p == 0) b = hdr_long;
      else if (p == 4) b = len[7:0];
      else if (p == total - 2) b = c[15:8];
      else if (p == total - 1) b = c[7:0] ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00);
      else b = 8'($urandom);
      if (p < total - 2) c = crc16_xmodem_update(c, b);
      queue_byte(b);
    end
    return n;
  endfunction

  function automatic int queue_short_frame();
    int n;
    n = (short_len < 2) ? 2 : short_len;
    if (n > KEEP_MAX) n = KEEP_MAX;
    queue_byte(hdr_short);
    for (int p = 1; p < n; p++) queue_byte(8'($urandom));
    return n;
  endfunction

  function automatic int pick_long_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 92) return $urandom_range(13, 57);
    return $urandom_range(58, 255);
  endfunction

  function automatic void random_traffic(input int target);
    int got;
    int r;
    int len;
    got = 0;
    while (got < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        got += queue_long_frame(pick_long_len(), 1'b0, KEEP_MAX);
      end else if (r < 70) begin
        got += queue_short_frame();
      end else if (r < 80) begin
        got += queue_long_frame(pick_long_len(), 1'b1, KEEP_MAX);
      end else if (r < 90) begin
        len = $urandom_range(0, 12);
        got += queue_long_frame(len, 1'b0, $urandom_range(1, len + 6));
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
    end
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SHORT_HEADER: hdr_short = val;
      REG_LONG_HEADER:  hdr_long  = val;
      REG_SHORT_LEN:    short_len = val[SLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (bytes_sent != bytes_queued || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // byte sender
  always @(posedge clk) begin : driver
    result_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (deframe_byte(rx_byte, predicted)) results_due.push_back(predicted);
        bytes_sent++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_stream.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte  <= byte_stream.pop_front();
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected transaction: data_byte %0d position %0d", data_byte, position);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (data_byte !== want.data_byte) begin
            $error("data_byte: expected %0d, got %0d", want.data_byte, data_byte);
            errors++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
        end
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("serial_frame_receiver_crc_check_top test failed");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] set_short[7];
    logic [BYTE_W-1:0] set_long[7];
    logic [BYTE_W-1:0] set_len[7];
    set_short = '{8'h00, 8'hA5, 8'h7E, 8'hFF, 8'h01, 8'h5A, 8'h00};
    set_long  = '{8'hFF, 8'hA5, 8'h81, 8'h00, 8'h5A, 8'h01, 8'h00};
    set_len   = '{8'h02, 8'h80, 8'h40, 8'h05, 8'h7F, 8'h81, 8'h00};
    set_short[6] = 8'($urandom);
    set_long[6]  = 8'($urandom);
    set_len[6]   = 8'($urandom_range(2, 64));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: noise, short frame, good and bad crc, longest fitting, overflow
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h5B);
    void'(queue_short_frame());
    void'(queue_long_frame(0, 1'b0, KEEP_MAX));
    void'(queue_long_frame(0, 1'b1, KEEP_MAX));
    void'(queue_long_frame(3, 1'b0, KEEP_MAX));
    void'(queue_long_frame(57, 1'b0, KEEP_MAX));
    void'(queue_long_frame(58, 1'b0, KEEP_MAX));
    void'(queue_long_frame(255, 1'b0, KEEP_MAX));
    void'(queue_long_frame(131, 1'b0, KEEP_MAX));
    queue_byte(8'h01);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h55);
    wait_idle();

    for (int k = 0; k < 7; k++) begin
      write_reg(REG_SHORT_HEADER, set_short[k]);
      write_reg(REG_LONG_HEADER, set_long[k]);
      write_reg(REG_SHORT_LEN, set_len[k]);
      cfg_valid <= 1'b0;
      steady = (k == 2 || k == 6);
      random_traffic(PHASE_BYTES);
      wait_idle();
    end

    if (errors == 0) begin
      $display("serial_frame_receiver_crc_check_top test passed");
    end else begin
      $display("serial_frame_receiver_crc_check_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sfrc_pkg.sv
hw/rtl/sfrc_cfg.sv
hw/rtl/sfrc_core.sv
hw/rtl/serial_frame_receiver_crc_check_top.sv
tb/testbench.sv
